// ===== rtl/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// types and constants shared by the slotted page manager
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int MAX_SLOTS       = 64;
    localparam int SLOT_W          = $clog2(MAX_SLOTS);
    localparam int COUNT_W         = SLOT_W + 1;
    localparam int RECORD_BITS     = 64;
    localparam int RECORD_BYTES    = 20;
    localparam int PAGE_W          = 13;
    localparam int DIR_ENTRY_SHIFT = 2;
    localparam int PAGE_OVERHEAD   = 2;
    localparam int PAGE_RESET      = 512;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SLOT = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [SLOT_W-1:0]      slot_id;
        logic [RECORD_BITS-1:0] record_data;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [SLOT_W-1:0]      result_slot;
        logic [RECORD_BITS-1:0] result_data;
    } rsp_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] index;
    } free_slot_t;

endpackage

// ===== rtl/spm_free_slot_finder.sv =====
// ----------------------------------------------------------------------------
// spm_free_slot_finder
// priority encoder: lowest clear bit of the slot valid vector
// ----------------------------------------------------------------------------
module spm_free_slot_finder (
    input  logic [spm_pkg::MAX_SLOTS-1:0] slot_valid,
    output spm_pkg::free_slot_t           free_slot
);
    import spm_pkg::*;

    always_comb
    begin
        free_slot = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid[i])
            begin
                free_slot.found = 1'b1;
                free_slot.index = SLOT_W'(i);
            end
        end
    end

endmodule

// ===== rtl/slotted_page_manager_unit.sv =====
// ----------------------------------------------------------------------------
// slotted_page_manager_unit
// slot directory and record store of one page with fixed-size records
// ----------------------------------------------------------------------------
// A request beat (add, get or delete) is taken on a clock edge where start is
// high and busy is low; busy never rises, so one request can be taken every
// cycle. The response beat appears on rsp in the next cycle, marked by a
// one-cycle done strobe, in request order. The receiver cannot stall: each
// response is shown for one cycle only.
// The free slot search, the space check and the state update run between the
// request ports and the response register, and the record store is read at
// the same edge into its registered read port.
// Writing page_bytes (cfg_we with cfg_data) reformats the page: all slots
// are freed, the slot count drops to zero and the free-region top becomes
// page_bytes minus two, floored at zero. Write it only while no response is
// pending. Reset sets page_bytes to 512 and formats the page the same way; the
// record store has no reset value; its data is used only at slots an add wrote.
// ----------------------------------------------------------------------------
module slotted_page_manager_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  spm_pkg::req_t               req,
    input  logic                        cfg_we,
    input  logic [spm_pkg::PAGE_W-1:0]  cfg_data,
    output logic                        done,
    output spm_pkg::rsp_t               rsp
);
    import spm_pkg::*;

    logic [MAX_SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic [COUNT_W-1:0]     slot_count_reg, slot_count_next;
    logic [PAGE_W-1:0]      region_top_reg, region_top_next;
    logic [RECORD_BITS-1:0] record_store [MAX_SLOTS];
    logic [RECORD_BITS-1:0] rd_data_reg;

    logic                   done_reg;
    status_t                status_reg, status_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   get_hit_reg, get_hit_next;

    free_slot_t             free_slot;
    logic                   accept;
    logic                   store_we;
    logic                   slot_hit;
    logic                   add_ok;
    logic [PAGE_W-1:0]      need;
    logic [PAGE_W-1:0]      format_top;

    spm_free_slot_finder u_free_slot_finder (
        .slot_valid (slot_valid_reg),
        .free_slot  (free_slot)
    );

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign need = PAGE_W'(RECORD_BYTES)
                + (PAGE_W'(slot_count_reg) << DIR_ENTRY_SHIFT);
    assign add_ok   = free_slot.found && (region_top_reg >= need);
    assign slot_hit = slot_valid_reg[req.slot_id];

    assign format_top = (cfg_data >= PAGE_W'(PAGE_OVERHEAD))
                      ? cfg_data - PAGE_W'(PAGE_OVERHEAD) : '0;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_count_next = slot_count_reg;
        region_top_next = region_top_reg;
        status_next     = ST_BAD_SLOT;
        slot_next       = req.slot_id;
        get_hit_next    = 1'b0;
        store_we        = 1'b0;
        if (cfg_we)
        begin
            slot_valid_next = '0;
            slot_count_next = '0;
            region_top_next = format_top;
        end
        else if (accept)
        begin
            case (req.cmd)
                CMD_ADD:
                begin
                    if (add_ok)
                    begin
                        status_next                      = ST_OK;
                        slot_next                        = free_slot.index;
                        store_we                         = 1'b1;
                        slot_valid_next[free_slot.index] = 1'b1;
                        region_top_next = region_top_reg - PAGE_W'(RECORD_BYTES);
                        if (COUNT_W'(free_slot.index) == slot_count_reg)
                        begin
                            slot_count_next = slot_count_reg + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                CMD_GET:
                begin
                    if (slot_hit)
                    begin
                        status_next  = ST_OK;
                        get_hit_next = 1'b1;
                    end
                end
                CMD_DELETE:
                begin
                    if (slot_hit)
                    begin
                        status_next                  = ST_OK;
                        slot_valid_next[req.slot_id] = 1'b0;
                        region_top_next = region_top_reg + PAGE_W'(RECORD_BYTES);
                    end
                end
                default:
                begin
                    status_next = ST_BAD_SLOT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            slot_count_reg <= '0;
            region_top_reg <= PAGE_W'(PAGE_RESET - PAGE_OVERHEAD);
            done_reg       <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            slot_count_reg <= slot_count_next;
            region_top_reg <= region_top_next;
            done_reg       <= accept && !cfg_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            slot_reg    <= slot_next;
            get_hit_reg <= get_hit_next;
        end
    end

    // record store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            record_store[free_slot.index] <= req.record_data;
        end
        if (accept)
        begin
            rd_data_reg <= record_store[req.slot_id];
        end
    end

    assign done = done_reg;

    always_comb
    begin
        rsp.status      = status_reg;
        rsp.result_slot = slot_reg;
        rsp.result_data = get_hit_reg ? rd_data_reg : '0;
    end

endmodule

// ===== tb/slotted_page_manager_unit_test.sv =====
// ----------------------------------------------------------------------------
// slotted_page_manager_unit_test
// self-checking bench for the slotted page manager: directed and random
// add, get and delete beats over several page sizes, each response beat
// compared field by field with a behavioral model of the page directory
// ----------------------------------------------------------------------------
module slotted_page_manager_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         MAX_SHOWN  = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    req_t                   req;
    logic                   cfg_we;
    logic [PAGE_W-1:0]      cfg_data;
    logic                   done;
    rsp_t                   rsp;

    // page model
    logic                   slot_used [MAX_SLOTS];
    logic [RECORD_BITS-1:0] rec_mem   [MAX_SLOTS];
    int unsigned            used_slots;
    logic [PAGE_W-1:0]      free_top;

    req_t                   req_backlog [$];
    rsp_t                   pending_rsp [$];
    int unsigned            reqs_queued;
    int unsigned            reqs_taken;
    int unsigned            bad_beats;
    logic                   req_taken;
    int unsigned            burst_left;
    int unsigned            gap_left;

    slotted_page_manager_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .rsp      (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void format_page(logic [PAGE_W-1:0] pb);
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            rec_mem[i]   = '0;
        end
        used_slots = 0;
        free_top   = (pb >= PAGE_OVERHEAD) ? PAGE_W'(pb - PAGE_OVERHEAD) : '0;
    endfunction

    function automatic rsp_t apply_page_op(req_t r);
        rsp_t        o;
        int unsigned need;
        int unsigned pick;
        o.status      = ST_BAD_SLOT;
        o.result_slot = r.slot_id;
        o.result_data = '0;
        case (r.cmd)
            CMD_ADD:
            begin
                need = RECORD_BYTES + (used_slots << DIR_ENTRY_SHIFT);
                pick = 0;
                while (pick < used_slots && slot_used[pick])
                    pick++;
                if (free_top < need || pick >= MAX_SLOTS)
                    o.status = ST_FULL;
                else
                begin
                    rec_mem[pick]   = r.record_data;
                    slot_used[pick] = 1'b1;
                    free_top        = PAGE_W'(free_top - RECORD_BYTES);
                    if (pick == used_slots)
                        used_slots++;
                    o.status      = ST_OK;
                    o.result_slot = pick[SLOT_W-1:0];
                end
            end
            CMD_GET, CMD_DELETE:
            begin
                if (r.slot_id < used_slots && slot_used[r.slot_id])
                begin
                    o.status = ST_OK;
                    if (r.cmd == CMD_GET)
                        o.result_data = rec_mem[r.slot_id];
                    else
                    begin
                        slot_used[r.slot_id] = 1'b0;
                        free_top = PAGE_W'(free_top + RECORD_BYTES);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // request driver: bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!start || req_taken))
        begin
            if (gap_left != 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (req_backlog.size() != 0)
            begin
                req   <= req_backlog.pop_front();
                start <= 1'b1;
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        burst_left = 200;
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    burst_left--;
            end
            else
                start <= 1'b0;
        end
    end

    // response monitor and request capture
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= MAX_SHOWN)
                        $display("unexpected response beat: status %0d slot %0d data %h",
                                 rsp.status, rsp.result_slot, rsp.result_data);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.result_slot !== want.result_slot ||
                        rsp.result_data !== want.result_data)
                    begin
                        bad_beats++;
                        if (bad_beats <= MAX_SHOWN)
                            $display("mismatch: expected status %0d slot %0d data %h,",
                                     want.status, want.result_slot, want.result_data,
                                     " got status %0d slot %0d data %h",
                                     rsp.status, rsp.result_slot, rsp.result_data);
                    end
                end
            end
            if (cfg_we)
                format_page(cfg_data);
            req_taken = start && !busy;
            if (req_taken)
            begin
                pending_rsp.push_back(apply_page_op(req));
                reqs_taken++;
            end
        end
    end

    task automatic push_req(cmd_t c, logic [SLOT_W-1:0] s, logic [RECORD_BITS-1:0] d);
        req_t r;
        r.cmd         = c;
        r.slot_id     = s;
        r.record_data = d;
        req_backlog.push_back(r);
        reqs_queued++;
    endtask

    task automatic wait_drained();
        while (reqs_taken != reqs_queued || pending_rsp.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_page(logic [PAGE_W-1:0] pb);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= pb;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [RECORD_BITS-1:0] rand_record();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '1;
        else if (pick == 1)
            return '0;
        return {$urandom, $urandom};
    endfunction

    task automatic queue_random(int n, int unsigned slot_hi, int unsigned add_pct);
        int unsigned      roll;
        logic [SLOT_W-1:0] s;
        cmd_t             c;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                c = CMD_ADD;
            else if (roll < 98)
                c = ($urandom_range(0, 9) < 6) ? CMD_GET : CMD_DELETE;
            else
                c = cmd_t'(CMD_UNUSED);
            if ($urandom_range(0, 4) != 0)
                s = SLOT_W'($urandom_range(0, slot_hi));
            else
                s = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
            push_req(c, s, rand_record());
        end
    endtask

    initial
    begin
        #500000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [PAGE_W-1:0] pb;
        int unsigned       hi;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        req_taken   = 1'b0;
        reqs_queued = 0;
        reqs_taken  = 0;
        bad_beats   = 0;
        burst_left  = 1;
        gap_left    = 0;
        format_page(PAGE_W'(PAGE_RESET));
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset page size, empty page, reuse of freed slots
        push_req(CMD_GET, 6'd0, '0);
        push_req(CMD_DELETE, 6'd63, '0);
        push_req(cmd_t'(CMD_UNUSED), 6'd63, '1);
        push_req(CMD_ADD, 6'd63, '1);
        push_req(CMD_ADD, 6'd0, '0);
        push_req(CMD_ADD, 6'd17, 64'hA5A5_5A5A_0F0F_F0F0);
        push_req(CMD_GET, 6'd0, '0);
        push_req(CMD_GET, 6'd1, '1);
        push_req(CMD_GET, 6'd2, '0);
        push_req(CMD_GET, 6'd3, '0);
        push_req(CMD_DELETE, 6'd1, '0);
        push_req(CMD_GET, 6'd1, '0);
        push_req(CMD_DELETE, 6'd1, '0);
        push_req(CMD_ADD, 6'd42, 64'h0123_4567_89AB_CDEF);
        push_req(CMD_GET, 6'd1, '0);
        push_req(CMD_GET, 6'd63, '0);

        // 16-byte page: no room for any record
        write_page(PAGE_W'(16));
        push_req(CMD_ADD, 6'd0, '1);
        push_req(CMD_GET, 6'd0, '0);
        push_req(CMD_DELETE, 6'd0, '0);

        // page fills after two records
        write_page(PAGE_W'(64));
        for (int i = 0; i < 4; i++)
            push_req(CMD_ADD, 6'd0, rand_record());
        push_req(CMD_DELETE, 6'd1, '0);
        push_req(CMD_ADD, 6'd0, rand_record());
        push_req(CMD_GET, 6'd1, '0);

        // page below the header size
        write_page(PAGE_W'(1));
        push_req(CMD_ADD, 6'd0, '1);
        push_req(CMD_GET, 6'd0, '0);

        // largest page: slot directory runs out
        write_page(PAGE_W'(4096));
        for (int i = 0; i < MAX_SLOTS + 2; i++)
            push_req(CMD_ADD, 6'd0, rand_record());
        push_req(CMD_GET, 6'd63, '0);
        push_req(CMD_DELETE, 6'd5, '0);
        push_req(CMD_ADD, 6'd0, rand_record());
        push_req(CMD_ADD, 6'd0, rand_record());
        push_req(CMD_GET, 6'd5, '0);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: pb = PAGE_W'(512);
                1: pb = PAGE_W'(4096);
                2: pb = PAGE_W'(16);
                3: pb = PAGE_W'($urandom_range(16, 4096));
                4: pb = PAGE_W'($urandom_range(16, 300));
                5: pb = PAGE_W'($urandom_range(300, 1500));
                6: pb = PAGE_W'(4096);
                default: pb = PAGE_W'($urandom_range(16, 4096));
            endcase
            write_page(pb);
            hi = pb / RECORD_BYTES;
            if (hi < 1)
                hi = 1;
            if (hi > MAX_SLOTS - 1)
                hi = MAX_SLOTS - 1;
            queue_random(125, hi, $urandom_range(35, 65));
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (bad_beats == 0 && pending_rsp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
